// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define PTW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PTW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTW_ASSERT(lbl, prop, msg)
`define PTW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// constants, codes and control/status types of the page table walker
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

	localparam int OFFSET_BITS = 4;
	localparam int LEVELS      = 3;
	localparam int VADDR_BITS  = 16;
	localparam int FRAME_COUNT = 64;
	localparam int WORD_BITS   = 32;

	localparam int PAGE_WORDS = 1 << OFFSET_BITS;
	localparam int FRAME_BITS = $clog2(FRAME_COUNT);
	localparam int PADDR_BITS = FRAME_BITS + OFFSET_BITS;
	localparam int PHYS_WORDS = FRAME_COUNT * PAGE_WORDS;
	localparam int PAGE_BITS  = VADDR_BITS - OFFSET_BITS;
	localparam int PAGE_COUNT = 1 << PAGE_BITS;
	localparam int SWAP_BITS  = VADDR_BITS;
	localparam int SWAP_WORDS = 1 << SWAP_BITS;
	localparam int DEPTH_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int DIST_BITS  = PAGE_BITS + 1;

	// port field widths
	localparam int CMD_W   = 2;
	localparam int VA_W    = 32;
	localparam int WV_W    = 32;
	localparam int VP_W    = 12;
	localparam int RV_W    = 32;
	localparam int FRAME_W = 6;
	localparam int IN_W    = ((VA_W + WV_W + VP_W + 7) / 8) * 8;
	localparam int OUT_W   = ((RV_W + FRAME_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_WRD, ST_WEV, ST_SRD, ST_SEV, ST_SNEXT, ST_SEND,
		ST_PICK, ST_VRD, ST_VEV, ST_VNEXT, ST_VSEL, ST_UNLF, ST_UNLV, ST_SVRD,
		ST_SVWR, ST_FRD, ST_FWR, ST_LINK, ST_ARD, ST_AEV, ST_FIN, ST_FAIL, ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLEAR, OP_LOAD, OP_WALK_RD, OP_WALK_EV, OP_SCAN_RD, OP_SCAN_EV,
		OP_SCAN_NEXT, OP_SCAN_END, OP_PICK, OP_VIC_RD, OP_VIC_EV, OP_VIC_NEXT,
		OP_VIC_SEL, OP_UNLINK, OP_SAVE_RD, OP_SAVE_WR, OP_FILL_RD, OP_FILL_WR,
		OP_LINK, OP_ACC_RD, OP_ACC_EV, OP_FINISH, OP_FAIL, OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic   accept;
		dp_op_t op;
	} dp_ctl_t;

	typedef struct packed {
		logic             clear_last;
		logic [CMD_W-1:0] in_cmd;
		logic             in_bad;
		logic [CMD_W-1:0] cmd;
		logic             entry_nz;
		logic             walk_last;
		logic             sd_zero;
		logic             sd_inner;
		logic             idx_last;
		logic             free_ok;
		logic             grow_ok;
		logic             vvalid;
		logic             cnt_last;
		logic             out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/ptw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptw_ctrl
// sequencer: walk, free-table scan, victim search, page moves
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  ptw_pkg::dp_stat_t  stat,
	output ptw_pkg::dp_ctl_t   ctl
);

	ptw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptw_pkg::ST_CLEAR: if (stat.clear_last) state_d = ptw_pkg::ST_IDLE;
			ptw_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (stat.in_cmd == ptw_pkg::CMD_NONE) state_d = ptw_pkg::ST_DONE;
					else if (stat.in_bad) state_d = ptw_pkg::ST_FAIL;
					else state_d = ptw_pkg::ST_WRD;
				end
			end
			ptw_pkg::ST_WRD: state_d = ptw_pkg::ST_WEV;
			ptw_pkg::ST_WEV: begin
				if (stat.entry_nz) begin
					if (!stat.walk_last) state_d = ptw_pkg::ST_WRD;
					else if (stat.cmd == ptw_pkg::CMD_QUERY) state_d = ptw_pkg::ST_FIN;
					else state_d = ptw_pkg::ST_ARD;
				end else if (stat.cmd == ptw_pkg::CMD_QUERY) begin
					state_d = ptw_pkg::ST_FIN;
				end else begin
					state_d = ptw_pkg::ST_SRD;
				end
			end
			ptw_pkg::ST_SRD: state_d = ptw_pkg::ST_SEV;
			ptw_pkg::ST_SEV: begin
				if (stat.entry_nz && stat.sd_inner) state_d = ptw_pkg::ST_SRD;
				else state_d = ptw_pkg::ST_SNEXT;
			end
			ptw_pkg::ST_SNEXT: state_d = stat.idx_last ? ptw_pkg::ST_SEND : ptw_pkg::ST_SRD;
			ptw_pkg::ST_SEND: begin
				if (stat.free_ok) state_d = ptw_pkg::ST_UNLF;
				else if (stat.sd_zero) state_d = ptw_pkg::ST_PICK;
				else state_d = ptw_pkg::ST_SNEXT;
			end
			ptw_pkg::ST_PICK: begin
				if (!stat.grow_ok) state_d = ptw_pkg::ST_VRD;
				else if (stat.walk_last) state_d = ptw_pkg::ST_FRD;
				else state_d = ptw_pkg::ST_FWR;
			end
			ptw_pkg::ST_VRD: state_d = ptw_pkg::ST_VEV;
			ptw_pkg::ST_VEV: begin
				if (stat.entry_nz && stat.sd_inner) state_d = ptw_pkg::ST_VRD;
				else state_d = ptw_pkg::ST_VNEXT;
			end
			ptw_pkg::ST_VNEXT: begin
				if (!stat.idx_last) state_d = ptw_pkg::ST_VRD;
				else if (stat.sd_zero) state_d = ptw_pkg::ST_VSEL;
			end
			ptw_pkg::ST_VSEL: state_d = stat.vvalid ? ptw_pkg::ST_UNLV : ptw_pkg::ST_FAIL;
			ptw_pkg::ST_UNLF: state_d = stat.walk_last ? ptw_pkg::ST_FRD : ptw_pkg::ST_FWR;
			ptw_pkg::ST_UNLV: state_d = ptw_pkg::ST_SVRD;
			ptw_pkg::ST_SVRD: state_d = ptw_pkg::ST_SVWR;
			ptw_pkg::ST_SVWR: begin
				if (!stat.cnt_last) state_d = ptw_pkg::ST_SVRD;
				else if (stat.walk_last) state_d = ptw_pkg::ST_FRD;
				else state_d = ptw_pkg::ST_FWR;
			end
			ptw_pkg::ST_FRD: state_d = ptw_pkg::ST_FWR;
			ptw_pkg::ST_FWR: begin
				if (stat.cnt_last) state_d = ptw_pkg::ST_LINK;
				else if (stat.walk_last) state_d = ptw_pkg::ST_FRD;
			end
			ptw_pkg::ST_LINK: state_d = stat.walk_last ? ptw_pkg::ST_ARD : ptw_pkg::ST_WRD;
			ptw_pkg::ST_ARD: begin
				state_d = (stat.cmd == ptw_pkg::CMD_READ) ? ptw_pkg::ST_AEV : ptw_pkg::ST_FIN;
			end
			ptw_pkg::ST_AEV: state_d = ptw_pkg::ST_FIN;
			ptw_pkg::ST_FIN: state_d = ptw_pkg::ST_DONE;
			ptw_pkg::ST_FAIL: state_d = ptw_pkg::ST_DONE;
			ptw_pkg::ST_DONE: if (stat.out_free) state_d = ptw_pkg::ST_IDLE;
			default: state_d = ptw_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl.accept = 1'b0;
		ctl.op     = ptw_pkg::OP_NOP;
		case (state_q)
			ptw_pkg::ST_CLEAR: ctl.op = ptw_pkg::OP_CLEAR;
			ptw_pkg::ST_IDLE: begin
				ctl.accept = 1'b1;
				if (s_tvalid) ctl.op = ptw_pkg::OP_LOAD;
			end
			ptw_pkg::ST_WRD:   ctl.op = ptw_pkg::OP_WALK_RD;
			ptw_pkg::ST_WEV:   ctl.op = ptw_pkg::OP_WALK_EV;
			ptw_pkg::ST_SRD:   ctl.op = ptw_pkg::OP_SCAN_RD;
			ptw_pkg::ST_SEV:   ctl.op = ptw_pkg::OP_SCAN_EV;
			ptw_pkg::ST_SNEXT: ctl.op = ptw_pkg::OP_SCAN_NEXT;
			ptw_pkg::ST_SEND:  ctl.op = ptw_pkg::OP_SCAN_END;
			ptw_pkg::ST_PICK:  ctl.op = ptw_pkg::OP_PICK;
			ptw_pkg::ST_VRD:   ctl.op = ptw_pkg::OP_VIC_RD;
			ptw_pkg::ST_VEV:   ctl.op = ptw_pkg::OP_VIC_EV;
			ptw_pkg::ST_VNEXT: ctl.op = ptw_pkg::OP_VIC_NEXT;
			ptw_pkg::ST_VSEL:  ctl.op = ptw_pkg::OP_VIC_SEL;
			ptw_pkg::ST_UNLF:  ctl.op = ptw_pkg::OP_UNLINK;
			ptw_pkg::ST_UNLV:  ctl.op = ptw_pkg::OP_UNLINK;
			ptw_pkg::ST_SVRD:  ctl.op = ptw_pkg::OP_SAVE_RD;
			ptw_pkg::ST_SVWR:  ctl.op = ptw_pkg::OP_SAVE_WR;
			ptw_pkg::ST_FRD:   ctl.op = ptw_pkg::OP_FILL_RD;
			ptw_pkg::ST_FWR:   ctl.op = ptw_pkg::OP_FILL_WR;
			ptw_pkg::ST_LINK:  ctl.op = ptw_pkg::OP_LINK;
			ptw_pkg::ST_ARD:   ctl.op = ptw_pkg::OP_ACC_RD;
			ptw_pkg::ST_AEV:   ctl.op = ptw_pkg::OP_ACC_EV;
			ptw_pkg::ST_FIN:   ctl.op = ptw_pkg::OP_FINISH;
			ptw_pkg::ST_FAIL:  ctl.op = ptw_pkg::OP_FAIL;
			ptw_pkg::ST_DONE:  if (stat.out_free) ctl.op = ptw_pkg::OP_OUT;
			default:           ctl.op = ptw_pkg::OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ptw_dp.sv =====
// ----------------------------------------------------------------------------
// ptw_dp
// datapath: physical and swap memories, depth-first stack, result registers
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptw_pkg::dp_ctl_t                ctl,
	output ptw_pkg::dp_stat_t               stat,
	input  logic [ptw_pkg::CMD_W-1:0]       s_tuser,
	input  logic [ptw_pkg::IN_W-1:0]        s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ptw_pkg::OUT_W-1:0]       m_tdata,
	output logic                            m_tuser
);

	localparam int OB = ptw_pkg::OFFSET_BITS;
	localparam int FB = ptw_pkg::FRAME_BITS;
	localparam int PB = ptw_pkg::PAGE_BITS;
	localparam int DB = ptw_pkg::DEPTH_BITS;
	localparam int AB = ptw_pkg::PADDR_BITS;
	localparam int SB = ptw_pkg::SWAP_BITS;
	localparam int WB = ptw_pkg::WORD_BITS;
	localparam int NL = ptw_pkg::LEVELS;

	// input fields
	logic [ptw_pkg::CMD_W-1:0] in_cmd;
	logic [ptw_pkg::VA_W-1:0]  in_va;
	logic [ptw_pkg::WV_W-1:0]  in_wv;
	logic [ptw_pkg::VP_W-1:0]  in_vp;

	// item and walk registers
	logic [ptw_pkg::CMD_W-1:0] cmd_q;
	logic [PB-1:0]             vpn_q;
	logic [OB-1:0]             off_q;
	logic [WB-1:0]             wval_q;
	logic [DB-1:0]             wd_q;
	logic [FB-1:0]             cur_q;
	logic [AB-1:0]             ea_q;

	// scan / victim registers
	logic [DB-1:0]             sd_q;
	logic [FB-1:0]             sfr_q [NL];
	logic [OB-1:0]             sidx_q [NL];
	logic [NL-1:0]             sempty_q;
	logic [FB-1:0]             largest_q;
	logic [FB-1:0]             chosen_q;
	logic [AB-1:0]             unlink_q;
	logic                      vvalid_q;
	logic [ptw_pkg::DIST_BITS-1:0] vdist_q;
	logic [FB-1:0]             vframe_q;
	logic [PB-1:0]             vpage_q;
	logic [AB-1:0]             vparent_q;
	logic [OB-1:0]             cnt_q;
	logic [SB-1:0]             clr_q;

	// results
	logic [WB-1:0]             res_rv_q;
	logic [FB-1:0]             res_fr_q;
	logic                      res_st_q;
	logic                      m_tvalid_q;
	logic [ptw_pkg::RV_W-1:0]  m_rv_q;
	logic [ptw_pkg::FRAME_W-1:0] m_fr_q;
	logic                      m_st_q;

	// memories
	logic [WB-1:0] phys_mem [ptw_pkg::PHYS_WORDS];
	logic [WB-1:0] swap_mem [ptw_pkg::SWAP_WORDS];
	logic [WB-1:0] prdata_q, srdata_q;

	logic          pwe, pre, swe, sre;
	logic [AB-1:0] pwaddr, praddr;
	logic [WB-1:0] pwdata, swdata;
	logic [SB-1:0] swaddr, sraddr;

	// combinational helpers
	logic [OB-1:0] widx;
	logic [AB-1:0] walk_addr, tbl_addr, parent_addr;
	logic [DB-1:0] sd_prev, sd_next;
	logic          entry_nz, leaf, free_ok, grow_ok, sd_inner;
	logic [FB-1:0] efr;
	logic [PB-1:0] lpage, diff;
	logic [ptw_pkg::DIST_BITS-1:0] other, cyc;

	assign in_cmd = s_tuser;
	assign in_va  = s_tdata[ptw_pkg::VA_W-1:0];
	assign in_wv  = s_tdata[ptw_pkg::VA_W+ptw_pkg::WV_W-1:ptw_pkg::VA_W];
	assign in_vp  = s_tdata[ptw_pkg::VA_W+ptw_pkg::WV_W+ptw_pkg::VP_W-1:
		ptw_pkg::VA_W+ptw_pkg::WV_W];

	assign widx      = OB'(vpn_q >> (OB * (NL - 1 - int'(wd_q))));
	assign walk_addr = {cur_q, widx};
	assign tbl_addr  = {sfr_q[sd_q], sidx_q[sd_q]};
	assign sd_prev   = (sd_q == '0) ? '0 : sd_q - 1'b1;
	assign sd_next   = sd_q + 1'b1;
	assign parent_addr = {sfr_q[sd_prev], sidx_q[sd_prev]};
	assign entry_nz  = |prdata_q;
	assign efr       = prdata_q[FB-1:0];
	assign leaf      = (wd_q == DB'(NL - 1));
	assign sd_inner  = (sd_q < DB'(NL - 1));
	assign free_ok   = sempty_q[sd_q] && (sfr_q[sd_q] != '0)
		&& (sfr_q[sd_q] != ea_q[AB-1:OB]);
	assign grow_ok   = (({1'b0, largest_q} + 1'b1) < (FB+1)'(ptw_pkg::FRAME_COUNT));

	// page number of the leaf under the current stack path
	always_comb begin
		lpage = '0;
		for (int k = 0; k < NL; k++) begin
			lpage = PB'((lpage << OB) | PB'(sidx_q[k]));
		end
	end

	// cyclic page distance to the page being brought in
	assign diff  = (vpn_q > lpage) ? (vpn_q - lpage) : (lpage - vpn_q);
	assign other = ptw_pkg::DIST_BITS'(ptw_pkg::PAGE_COUNT) - {1'b0, diff};
	assign cyc   = ({1'b0, diff} < other) ? {1'b0, diff} : other;

	// memory port selection
	always_comb begin
		pwe = 1'b0; pwaddr = '0; pwdata = '0; pre = 1'b0; praddr = '0;
		swe = 1'b0; swaddr = '0; swdata = '0; sre = 1'b0; sraddr = '0;
		case (ctl.op)
			ptw_pkg::OP_CLEAR: begin
				pwe = 1'b1; pwaddr = clr_q[AB-1:0];
				swe = 1'b1; swaddr = clr_q;
			end
			ptw_pkg::OP_WALK_RD: begin
				pre = 1'b1; praddr = walk_addr;
			end
			ptw_pkg::OP_SCAN_RD, ptw_pkg::OP_VIC_RD: begin
				pre = 1'b1; praddr = tbl_addr;
			end
			ptw_pkg::OP_SAVE_RD: begin
				pre = 1'b1; praddr = {vframe_q, cnt_q};
			end
			ptw_pkg::OP_SAVE_WR: begin
				swe = 1'b1; swaddr = {vpage_q, cnt_q}; swdata = prdata_q;
			end
			ptw_pkg::OP_FILL_RD: begin
				sre = 1'b1; sraddr = {vpn_q, cnt_q};
			end
			ptw_pkg::OP_FILL_WR: begin
				pwe = 1'b1; pwaddr = {chosen_q, cnt_q};
				pwdata = leaf ? srdata_q : '0;
			end
			ptw_pkg::OP_UNLINK: begin
				pwe = 1'b1; pwaddr = unlink_q;
			end
			ptw_pkg::OP_LINK: begin
				pwe = 1'b1; pwaddr = ea_q; pwdata = WB'(chosen_q);
			end
			ptw_pkg::OP_ACC_RD: begin
				if (cmd_q == ptw_pkg::CMD_WRITE) begin
					pwe = 1'b1; pwaddr = {cur_q, off_q}; pwdata = wval_q;
				end else begin
					pre = 1'b1; praddr = {cur_q, off_q};
				end
			end
			default: pwe = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pwe) phys_mem[pwaddr] <= pwdata;
		if (pre) prdata_q <= phys_mem[praddr];
	end

	always_ff @(posedge clk) begin
		if (swe) swap_mem[swaddr] <= swdata;
		if (sre) srdata_q <= swap_mem[sraddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.op == ptw_pkg::OP_CLEAR) clr_q <= clr_q + 1'b1;
			if (ctl.op == ptw_pkg::OP_OUT) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			ptw_pkg::OP_LOAD: begin
				cmd_q    <= in_cmd;
				vpn_q    <= (in_cmd == ptw_pkg::CMD_QUERY) ? in_vp[PB-1:0]
					: in_va[ptw_pkg::VADDR_BITS-1:OB];
				off_q    <= in_va[OB-1:0];
				wval_q   <= in_wv;
				wd_q     <= '0;
				cur_q    <= '0;
				res_rv_q <= '0;
				res_fr_q <= '0;
				res_st_q <= 1'b0;
			end
			ptw_pkg::OP_WALK_EV: begin
				cur_q <= efr;
				if (entry_nz && !leaf) wd_q <= wd_q + 1'b1;
				if (!entry_nz && cmd_q != ptw_pkg::CMD_QUERY) begin
					ea_q        <= walk_addr;
					sd_q        <= '0;
					sfr_q[0]    <= '0;
					sidx_q[0]   <= '0;
					sempty_q[0] <= 1'b1;
					largest_q   <= '0;
				end
			end
			ptw_pkg::OP_SCAN_EV: begin
				if (entry_nz) begin
					sempty_q[sd_q] <= 1'b0;
					if (efr > largest_q) largest_q <= efr;
					if (sd_inner) begin
						sd_q              <= sd_next;
						sfr_q[sd_next]    <= efr;
						sidx_q[sd_next]   <= '0;
						sempty_q[sd_next] <= 1'b1;
					end
				end
			end
			ptw_pkg::OP_SCAN_NEXT: begin
				if (!(&sidx_q[sd_q])) sidx_q[sd_q] <= sidx_q[sd_q] + 1'b1;
			end
			ptw_pkg::OP_SCAN_END: begin
				if (free_ok) begin
					chosen_q <= sfr_q[sd_q];
					unlink_q <= parent_addr;
				end else if (sd_q != '0) begin
					sd_q <= sd_prev;
				end
			end
			ptw_pkg::OP_PICK: begin
				cnt_q <= '0;
				if (grow_ok) begin
					chosen_q <= largest_q + 1'b1;
				end else begin
					sd_q      <= '0;
					sfr_q[0]  <= '0;
					sidx_q[0] <= '0;
					vvalid_q  <= 1'b0;
				end
			end
			ptw_pkg::OP_VIC_EV: begin
				if (entry_nz) begin
					if (sd_inner) begin
						sd_q            <= sd_next;
						sfr_q[sd_next]  <= efr;
						sidx_q[sd_next] <= '0;
					end else if (!vvalid_q || cyc > vdist_q) begin
						vvalid_q  <= 1'b1;
						vdist_q   <= cyc;
						vframe_q  <= efr;
						vpage_q   <= lpage;
						vparent_q <= tbl_addr;
					end
				end
			end
			ptw_pkg::OP_VIC_NEXT: begin
				if (&sidx_q[sd_q]) begin
					if (sd_q != '0) sd_q <= sd_prev;
				end else begin
					sidx_q[sd_q] <= sidx_q[sd_q] + 1'b1;
				end
			end
			ptw_pkg::OP_VIC_SEL: begin
				chosen_q <= vframe_q;
				unlink_q <= vparent_q;
				cnt_q    <= '0;
			end
			ptw_pkg::OP_UNLINK: cnt_q <= '0;
			ptw_pkg::OP_SAVE_WR, ptw_pkg::OP_FILL_WR: cnt_q <= cnt_q + 1'b1;
			ptw_pkg::OP_LINK: begin
				cur_q <= chosen_q;
				if (!leaf) wd_q <= wd_q + 1'b1;
			end
			ptw_pkg::OP_ACC_EV: res_rv_q <= prdata_q;
			ptw_pkg::OP_FINISH: res_fr_q <= cur_q;
			ptw_pkg::OP_FAIL: begin
				res_st_q <= 1'b1;
				res_fr_q <= '0;
				res_rv_q <= '0;
			end
			ptw_pkg::OP_OUT: begin
				m_rv_q <= ptw_pkg::RV_W'(res_rv_q);
				m_fr_q <= ptw_pkg::FRAME_W'(res_fr_q);
				m_st_q <= res_st_q;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(ptw_pkg::OUT_W - ptw_pkg::RV_W - ptw_pkg::FRAME_W){1'b0}}, m_fr_q, m_rv_q};
	assign m_tuser  = m_st_q;

	always_comb begin
		stat.clear_last = &clr_q;
		stat.in_cmd     = in_cmd;
		stat.in_bad     = (((in_cmd == ptw_pkg::CMD_READ) || (in_cmd == ptw_pkg::CMD_WRITE))
			&& ((in_va >> ptw_pkg::VADDR_BITS) != '0))
			|| ((in_cmd == ptw_pkg::CMD_QUERY) && ((in_vp >> PB) != '0));
		stat.cmd        = cmd_q;
		stat.entry_nz   = entry_nz;
		stat.walk_last  = leaf;
		stat.sd_zero    = (sd_q == '0);
		stat.sd_inner   = sd_inner;
		stat.idx_last   = &sidx_q[sd_q];
		stat.free_ok    = free_ok;
		stat.grow_ok    = grow_ok;
		stat.vvalid     = vvalid_q;
		stat.cnt_last   = &cnt_q;
		stat.out_free   = !m_tvalid_q || m_tready;
	end

endmodule

`default_nettype wire

// ===== design/page_table_walk_with_demand_paging.sv =====
// ----------------------------------------------------------------------------
// page_table_walk_with_demand_paging
// three-level page table walker over 64 frames of 16 words, demand paging
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake            payload
//   s_        in   s_tvalid/s_tready    s_tdata, s_tuser (command)
//   m_        out  m_tvalid/m_tready    m_tdata, m_tuser (status)
//
// - a hit reads one entry per table level, then any read or write access
// - a miss scans reachable table entries for an empty table to reuse, each
//   entry read through the single physical memory read port, once per
//   missing level; a full memory adds a second scan for the victim and a
//   word-by-word save of its page to swap
// - after reset the block clears swap and physical memory with s_tready low
// - one word at a time; a finished result waits in the output register while
//   the next word is taken
// ----------------------------------------------------------------------------
`default_nettype none

module page_table_walk_with_demand_paging (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// virtual_address [31:0], write_value [63:32], virtual_page [75:64]
	input  logic [ptw_pkg::IN_W-1:0]    s_tdata,
	// command [1:0]
	input  logic [ptw_pkg::CMD_W-1:0]   s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// read_value [31:0], frame [37:32]
	output logic [ptw_pkg::OUT_W-1:0]   m_tdata,
	// status [0]
	output logic                        m_tuser
);

	`include "assert_macros.svh"

	// controller to datapath commands and datapath status
	ptw_pkg::dp_ctl_t  ctl;
	ptw_pkg::dp_stat_t stat;

	ptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.ctl      (ctl)
	);

	ptw_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// input side is only open in idle
	assign s_tready = ctl.accept;

	// a taken word starts work, so the input closes on the next cycle
	`PTW_ASSERT(a_accept_closes, (s_tvalid && s_tready) |=> !s_tready, "input stayed open")
	// loading item registers only on a real handshake
	`PTW_ASSERT(a_load_on_accept, (ctl.op == ptw_pkg::OP_LOAD) |-> s_tvalid && s_tready, "bad load")
	// an ignored access never reports a frame
	`PTW_ASSERT(a_fail_no_frame, (m_tvalid && m_tuser) |-> m_tdata[37:32] == 6'd0, "frame on failure")
	// no result during reset
	`PTW_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "result during reset")

endmodule

`default_nettype wire
